// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of this project.
// Each macro expands to a labeled concurrent assertion, or to nothing under SYNTH.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

// File: rtl/core/gas_pkg.sv
// Package for the gradient aggregation slots block.
// Holds the default sizes, tag mask, result kind codes and configuration indices; no dependencies.
`default_nettype none
package gas_pkg;
    localparam int SLOTS_DEF       = 64;
    localparam int MAX_UPDATES_DEF = 32;
    localparam int MAX_WORKERS_DEF = 16;
    localparam logic [14:0] TAG_MASK = 15'h7FFF;

    localparam logic [1:0] KIND_SUM   = 2'd0;
    localparam logic [1:0] KIND_DEST  = 2'd1;
    localparam logic [1:0] KIND_RANGE = 2'd2;

    localparam logic [1:0] CFG_SLOT_BASE = 2'd0;
    localparam logic [1:0] CFG_WORKERS   = 2'd1;
    localparam logic [1:0] CFG_UPDATES   = 2'd2;
endpackage
`default_nettype wire

// File: rtl/core/gradient_aggregation_slots.sv
// Top level of the gradient aggregation slots block.
// Depends on gas_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
// One update item is taken at a time. An item whose slot is out of range passes
// through the accepting cycle, decode, and one result held until it is taken. An
// update item passes through the accepting cycle, decode, a read of the sum memory,
// and the add and write back through the one shared adder before the next accept.
// At end of packet the worker table is searched one entry a cycle (no search when
// the table is already full), then the packet is counted. A completing packet then
// drains the sum row: each of the active sums passes a memory read, an output load
// and a hand-off, the rest of the row is cleared one entry a cycle, and each worker
// result is loaded and then handed off; every result is held until taken.
// After reset a clearing pass writes zero through all SLOTS*MAX_UPDATES sum
// entries and the packet counts, one a cycle, before the first item is accepted;
// configuration writes are taken during it.
module gradient_aggregation_slots #(
    parameter int SLOTS       = gas_pkg::SLOTS_DEF,
    parameter int MAX_UPDATES = gas_pkg::MAX_UPDATES_DEF,
    parameter int MAX_WORKERS = gas_pkg::MAX_WORKERS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [14:0] i_cfg_data,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [15:0] i_pool_tag,
    input  wire  [31:0] i_update_value,
    input  wire  [31:0] i_worker_ip,
    input  wire  [47:0] i_worker_mac,
    input  wire         i_end_of_packet,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [1:0]  o_kind,
    output logic [5:0]  o_slot,
    output logic [31:0] o_sum_value,
    output logic [4:0]  o_position,
    output logic [31:0] o_dest_ip,
    output logic [47:0] o_dest_mac,
    output logic        o_last
);
    import gas_pkg::*;

    localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int UW  = (MAX_UPDATES > 1) ? $clog2(MAX_UPDATES) : 1;
    localparam int UCW = $clog2(MAX_UPDATES + 1);
    localparam int WW  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int WCW = $clog2(MAX_WORKERS + 1);
    localparam int DEPTH = SLOTS * MAX_UPDATES;
    localparam int AW  = SW + UW;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DECODE, ST_READ, ST_ADD, ST_SEARCH,
        ST_COUNT, ST_DRAIN_RD, ST_DRAIN_OUT, ST_WK_OUT, ST_RANGE_OUT
    } t_state;

    t_state r_state;

    logic [14:0] r_slot_base;
    logic [4:0]  r_worker_count;
    logic [5:0]  r_updates;

    logic [14:0] r_tag;
    logic [31:0] r_val;
    logic [31:0] r_ip;
    logic [47:0] r_mac;
    logic        r_eop;

    logic [31:0] r_sums [DEPTH];
    logic [31:0] r_rd_data;
    logic [AW-1:0] r_clr_addr;

    logic [4:0]     r_seen [SLOTS];
    logic [4:0]     r_seen_rd;
    logic [31:0]    r_kip  [MAX_WORKERS];
    logic [47:0]    r_kmac [MAX_WORKERS];
    logic [WCW-1:0] r_known;
    logic [UCW-1:0] r_uidx;
    logic [UCW-1:0] r_idx;
    logic [SW-1:0]  r_slot;
    logic [UCW-1:0] r_pos;
    logic [WCW-1:0] r_wpos;
    logic           r_found;

    logic [UCW-1:0] nupd;
    logic [WCW-1:0] nwk;
    logic [15:0]    diff;
    logic           in_range;
    logic [31:0]    add_sum;
    logic [AW-1:0]  acc_addr;
    logic [AW-1:0]  drn_addr;
    logic [4:0]     seen_inc;

    always_comb begin
        if (r_updates == 6'd0) begin
            nupd = UCW'(1);
        end else if (32'(r_updates) > MAX_UPDATES) begin
            nupd = UCW'(MAX_UPDATES);
        end else begin
            nupd = UCW'(r_updates);
        end
        if (r_worker_count == 5'd0) begin
            nwk = WCW'(1);
        end else if (32'(r_worker_count) > MAX_WORKERS) begin
            nwk = WCW'(MAX_WORKERS);
        end else begin
            nwk = WCW'(r_worker_count);
        end
        diff     = {1'b0, r_tag} - {1'b0, r_slot_base};
        in_range = (r_tag >= r_slot_base) && (32'(diff) < SLOTS);
        add_sum  = r_rd_data + r_val;
        acc_addr = {r_slot, r_idx[UW-1:0]};
        drn_addr = {r_slot, r_pos[UW-1:0]};
        seen_inc = r_seen_rd + 5'd1;
    end

    assign o_ready = (r_state == ST_IDLE);

    // Sum memory: one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            r_sums[r_clr_addr] <= 32'd0;
        end else if (r_state == ST_ADD && r_idx < nupd) begin
            r_sums[acc_addr] <= add_sum;
        end else if (r_state == ST_DRAIN_RD && r_pos >= nupd && 32'(r_pos) < MAX_UPDATES) begin
            r_sums[drn_addr] <= 32'd0;
        end else if (r_state == ST_DRAIN_OUT && i_ready) begin
            r_sums[drn_addr] <= 32'd0;
        end
        r_rd_data <= (r_state == ST_DRAIN_RD) ? r_sums[drn_addr] : r_sums[acc_addr];
    end

    // Packet count per slot, cleared by the same pass as the sums.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            r_seen[r_clr_addr[AW-1:UW]] <= 5'd0;
        end else if (r_state == ST_COUNT) begin
            r_seen[r_slot] <= (32'(seen_inc) < 32'(nwk)) ? seen_inc : 5'd0;
        end
        r_seen_rd <= r_seen[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_slot_base    <= 15'd0;
            r_worker_count <= 5'd1;
            r_updates      <= 6'd32;
            r_clr_addr     <= '0;
            r_known        <= '0;
            r_uidx         <= '0;
            o_valid        <= 1'b0;
            for (int k = 0; k < MAX_WORKERS; k++) begin
                r_kip[k]  <= 32'd0;
                r_kmac[k] <= 48'd0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SLOT_BASE: r_slot_base    <= i_cfg_data;
                    CFG_WORKERS:   r_worker_count <= i_cfg_data[4:0];
                    CFG_UPDATES:   r_updates      <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (32'(r_clr_addr) == DEPTH - 1) r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (i_valid) begin
                        r_tag   <= i_pool_tag[14:0] & TAG_MASK;
                        r_val   <= i_update_value;
                        r_ip    <= i_worker_ip;
                        r_mac   <= i_worker_mac;
                        r_eop   <= i_end_of_packet;
                        r_state <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    r_idx <= (r_uidx > nupd) ? nupd : r_uidx;
                    if (r_eop) begin
                        r_uidx <= '0;
                    end else if (r_uidx < nupd) begin
                        r_uidx <= r_uidx + UCW'(1);
                    end else begin
                        r_uidx <= nupd;
                    end
                    r_slot <= diff[SW-1:0];
                    if (!in_range) begin
                        o_valid     <= 1'b1;
                        o_kind      <= KIND_RANGE;
                        o_slot      <= 6'd0;
                        o_sum_value <= 32'd0;
                        o_position  <= 5'd0;
                        o_dest_ip   <= 32'd0;
                        o_dest_mac  <= 48'd0;
                        o_last      <= 1'b1;
                        r_state     <= ST_RANGE_OUT;
                    end else begin
                        r_state <= ST_READ;
                    end
                end
                ST_READ: r_state <= ST_ADD;
                ST_ADD: begin
                    r_wpos  <= '0;
                    r_found <= 1'b0;
                    r_state <= r_eop ? ST_SEARCH : ST_IDLE;
                end
                ST_SEARCH: begin
                    // Walk the known table; learn at the end if not found.
                    if (r_known >= nwk) begin
                        r_state <= ST_COUNT;
                    end else if (r_wpos < r_known) begin
                        if (r_kip[r_wpos[WW-1:0]] == r_ip) r_found <= 1'b1;
                        r_wpos <= r_wpos + WCW'(1);
                    end else begin
                        if (!r_found && 32'(r_known) < MAX_WORKERS) begin
                            r_kip[r_known[WW-1:0]]  <= r_ip;
                            r_kmac[r_known[WW-1:0]] <= r_mac;
                            r_known <= r_known + WCW'(1);
                        end
                        r_state <= ST_COUNT;
                    end
                end
                ST_COUNT: begin
                    r_pos  <= '0;
                    r_wpos <= '0;
                    if (32'(seen_inc) < 32'(nwk)) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_DRAIN_RD;
                    end
                end
                ST_DRAIN_RD: begin
                    if (r_pos < nupd) begin
                        r_state <= ST_DRAIN_OUT;
                    end else if (32'(r_pos) < MAX_UPDATES) begin
                        // Entries past the active count are cleared without a result.
                        r_pos <= r_pos + UCW'(1);
                    end else begin
                        o_valid     <= 1'b1;
                        o_kind      <= KIND_DEST;
                        o_slot      <= 6'(r_slot);
                        o_sum_value <= 32'd0;
                        o_position  <= 5'(r_wpos);
                        o_dest_ip   <= r_kip[r_wpos[WW-1:0]];
                        o_dest_mac  <= r_kmac[r_wpos[WW-1:0]];
                        o_last      <= (r_wpos == nwk - WCW'(1));
                        r_state     <= ST_WK_OUT;
                    end
                end
                ST_DRAIN_OUT: begin
                    if (!o_valid) begin
                        o_valid     <= 1'b1;
                        o_kind      <= KIND_SUM;
                        o_slot      <= 6'(r_slot);
                        o_sum_value <= r_rd_data;
                        o_position  <= 5'(r_pos);
                        o_dest_ip   <= 32'd0;
                        o_dest_mac  <= 48'd0;
                        o_last      <= 1'b0;
                    end else if (i_ready) begin
                        o_valid <= 1'b0;
                        r_pos   <= r_pos + UCW'(1);
                        r_state <= ST_DRAIN_RD;
                    end
                end
                ST_WK_OUT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        if (o_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_wpos  <= r_wpos + WCW'(1);
                            r_state <= ST_DRAIN_RD;
                        end
                    end
                end
                ST_RANGE_OUT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `ASSERT_CLK(a_no_accept_while_out, i_clk, i_rst_n, !(o_ready && o_valid))
    `ASSERT_CLK(a_known_bounded, i_clk, i_rst_n, 32'(r_known) <= MAX_WORKERS)
    `ASSERT_CLK(a_range_last, i_clk, i_rst_n, (o_valid && o_kind == KIND_RANGE) |-> o_last)
    `ASSERT_CLK(a_sum_not_last, i_clk, i_rst_n, (o_valid && o_kind == KIND_SUM) |-> !o_last)
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> o_valid)
endmodule
`default_nettype wire

// File: tb/tb_gradient_aggregation_slots.sv
// Self-checking testbench for gradient_aggregation_slots: directed and random packets,
// with a built-in slot and sum predictor. Depends on gas_pkg and the block's RTL.
`default_nettype none
module tb_gradient_aggregation_slots;
    import gas_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  slot;
        logic [31:0] sum_value;
        logic [4:0]  position;
        logic [31:0] dest_ip;
        logic [47:0] dest_mac;
        logic        last;
    } agg_result_t;

    localparam int NSLOTS = 64;
    localparam int NUPD = 32;
    localparam int NWK = 16;
    localparam int CYCLE_LIMIT = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = CFG_SLOT_BASE;
    logic [14:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [15:0] i_pool_tag = '0;
    logic [31:0] i_update_value = '0;
    logic [31:0] i_worker_ip = '0;
    logic [47:0] i_worker_mac = '0;
    logic i_end_of_packet = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [1:0] o_kind;
    logic [5:0] o_slot;
    logic [31:0] o_sum_value;
    logic [4:0] o_position;
    logic [31:0] o_dest_ip;
    logic [47:0] o_dest_mac;
    logic o_last;

    gradient_aggregation_slots dut (.*);

    always #6 i_clk = ~i_clk;

    // Predictor state.
    logic [14:0] base_reg;
    logic [4:0]  workers_reg;
    logic [5:0]  updates_reg;
    logic [31:0] slot_sums [NSLOTS*NUPD];
    logic [4:0]  packet_count [NSLOTS];
    logic [31:0] table_ip [NWK];
    logic [47:0] table_mac [NWK];
    int          table_size;
    int          cur_index;

    agg_result_t expected_results[$];
    int mismatches = 0;
    int cycles = 0;
    int stall_left = 0;
    bit quiet_tail = 1'b0;
    bit sink_stall_on = 1'b1;

    function automatic agg_result_t mk(logic [1:0] k, logic [5:0] s, logic [31:0] v,
                                       logic [4:0] p, logic [31:0] ip, logic [47:0] mac);
        agg_result_t r;
        r.kind = k; r.slot = s; r.sum_value = v; r.position = p;
        r.dest_ip = ip; r.dest_mac = mac; r.last = 1'b0;
        return r;
    endfunction

    task automatic predict_update(logic [15:0] tag_in, logic [31:0] val, logic [31:0] ip,
                                  logic [47:0] mac, logic eop);
        int tag, nupd, nwk, idx, slot, n0;
        bit found;
        agg_result_t r;
        tag = int'(tag_in[14:0]);
        nupd = (updates_reg < 1) ? 1 : (updates_reg > NUPD ? NUPD : updates_reg);
        nwk = (workers_reg < 1) ? 1 : (workers_reg > NWK ? NWK : workers_reg);
        idx = (cur_index > nupd) ? nupd : cur_index;
        cur_index = eop ? 0 : (idx < nupd ? idx + 1 : nupd);
        if (tag < base_reg || tag - base_reg >= NSLOTS) begin
            r = mk(KIND_RANGE, '0, '0, '0, '0, '0);
            r.last = 1'b1;
            expected_results.push_back(r);
            return;
        end
        slot = tag - base_reg;
        if (idx < nupd) slot_sums[slot*NUPD+idx] = slot_sums[slot*NUPD+idx] + val;
        if (!eop) return;
        if (table_size < nwk) begin
            found = 0;
            for (int i = 0; i < table_size; i++) if (table_ip[i] == ip) found = 1;
            if (!found) begin
                table_ip[table_size] = ip;
                table_mac[table_size] = mac;
                table_size++;
            end
        end
        packet_count[slot] = packet_count[slot] + 5'd1;
        if (packet_count[slot] < nwk) return;
        packet_count[slot] = '0;
        n0 = expected_results.size();
        for (int i = 0; i < nupd; i++)
            expected_results.push_back(mk(KIND_SUM, 6'(slot), slot_sums[slot*NUPD+i],
                                          5'(i), '0, '0));
        for (int i = 0; i < NUPD; i++) slot_sums[slot*NUPD+i] = '0;
        for (int i = 0; i < nwk; i++)
            expected_results.push_back(mk(KIND_DEST, 6'(slot), '0, 5'(i),
                                          table_ip[i], table_mac[i]));
        expected_results[expected_results.size()-1].last = 1'b1;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [14:0] val);
        i_valid <= 1'b0;
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_SLOT_BASE: base_reg = val;
            CFG_WORKERS: workers_reg = val[4:0];
            default: updates_reg = val[5:0];
        endcase
    endtask

    // Valid stays high after an accept until the next item, an idle gap or a
    // register write replaces it, so each step sees one drive of i_valid.
    task automatic send_item(logic [15:0] tag, logic [31:0] val, logic [31:0] ip,
                             logic [47:0] mac, logic eop);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid <= 1'b1; i_pool_tag <= tag; i_update_value <= val;
        i_worker_ip <= ip; i_worker_mac <= mac; i_end_of_packet <= eop;
        do @(posedge i_clk); while (!o_ready);
        predict_update(tag, val, ip, mac, eop);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // One packet of n updates; worker identity chosen by the caller.
    task automatic send_packet(int slot_tag, int n, logic [31:0] ip, logic [47:0] mac);
        for (int i = 0; i < n; i++)
            send_item(slot_tag[15:0], $urandom, ip, mac, i == n - 1);
    endtask

    task automatic test_directed();
        write_reg(CFG_UPDATES, 15'd2);
        write_reg(CFG_WORKERS, 15'd2);
        write_reg(CFG_SLOT_BASE, 15'd0);
        send_item(16'h8000, 32'h7FFFFFFF, 32'hFFFFFFFF, 48'hFFFFFFFFFFFF, 1'b0);
        send_item(16'h8000, 32'h80000000, 32'hFFFFFFFF, 48'hFFFFFFFFFFFF, 1'b1);
        send_item(16'h0000, 32'h7FFFFFFF, 32'h0, 48'h0, 1'b0);
        send_item(16'h0000, 32'h00000001, 32'h0, 48'h0, 1'b0);
        send_item(16'h0000, 32'hFFFFFFFF, 32'h0, 48'h0, 1'b1);  // extra update ignored
        send_item(16'd64, 32'h1, 32'h1, 48'h1, 1'b1);            // out of range above
        send_item(16'hFFFF, 32'h1, 32'h1, 48'h1, 1'b1);
        wait_idle();
        write_reg(CFG_SLOT_BASE, 15'h7FFF);
        send_item(16'h0005, 32'h5, 32'h2, 48'h2, 1'b1);          // below base
        send_item(16'hFFFF, 32'h80000000, 32'h2, 48'h2, 1'b1);
        wait_idle();
        // Workers lowered below a slot's count completes it on the next packet.
        write_reg(CFG_SLOT_BASE, 15'd10);
        write_reg(CFG_WORKERS, 15'd3);
        write_reg(CFG_UPDATES, 15'd1);
        send_item(16'd73, 32'h3, 32'hA, 48'hA, 1'b1);
        send_item(16'd73, 32'h4, 32'hB, 48'hB, 1'b1);
        wait_idle();
        write_reg(CFG_WORKERS, 15'd1);
        send_item(16'd73, 32'h5, 32'hC, 48'hC, 1'b1);
        wait_idle();
    endtask

    task automatic test_random(int total);
        int sent, nwk, n, tag;
        sent = 0;
        while (sent < total) begin
            case ($urandom_range(0, 2))
                0: write_reg(CFG_WORKERS, 15'($urandom_range(0, 31)));
                1: write_reg(CFG_UPDATES, 15'($urandom_range(0, 63)));
                default: write_reg(CFG_SLOT_BASE, 15'($urandom_range(0, 9) == 0 ?
                                   $urandom : $urandom_range(0, 100)));
            endcase
            if (updates_reg > 6) write_reg(CFG_UPDATES, 15'($urandom_range(1, 6)));
            if (workers_reg > 4 && $urandom_range(0, 3) != 0)
                write_reg(CFG_WORKERS, 15'($urandom_range(1, 4)));
            nwk = (workers_reg < 1) ? 1 : (workers_reg > NWK ? NWK : workers_reg);
            repeat ($urandom_range(1, 3)) begin
                tag = base_reg + $urandom_range(0, 3);
                for (int w = 0; w < nwk && sent < total; w++) begin
                    n = (updates_reg == 0 ? 1 : updates_reg) + $urandom_range(0, 4) - 2;
                    if (n < 1) n = 1;
                    if ($urandom_range(0, 9) == 0)
                        send_item(16'($urandom), $urandom, $urandom,
                                  48'({$urandom, $urandom}), 1'($urandom_range(0, 1)));
                    send_packet(32'({1'($urandom_range(0, 1)), tag[14:0]}), n,
                                $urandom_range(0, 5) == 0 ? $urandom : 32'h100 + w,
                                48'({$urandom, $urandom}));
                    sent += n;
                end
            end
            wait_idle();
        end
    endtask

    // Result checker and output-side idling.
    always @(posedge i_clk) begin
        agg_result_t got, want;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_kind, o_slot, o_sum_value, o_position, o_dest_ip, o_dest_mac, o_last};
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %h actual %h", want, got);
                end
            end
        end
        if (!sink_stall_on || quiet_tail) begin
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            i_ready <= 1'b0;
            stall_left <= $urandom_range(0, 11);
        end else begin
            i_ready <= 1'b1;
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_gradient_aggregation_slots NOT OK");
            $finish;
        end
    end

    initial begin
        base_reg = 0; workers_reg = 1; updates_reg = 32;
        for (int i = 0; i < NSLOTS*NUPD; i++) slot_sums[i] = '0;
        for (int i = 0; i < NSLOTS; i++) packet_count[i] = '0;
        for (int i = 0; i < NWK; i++) begin table_ip[i] = '0; table_mac[i] = '0; end
        table_size = 0; cur_index = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(260);
        quiet_tail = 1'b1;
        test_random(60);
        wait_idle();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb_gradient_aggregation_slots OK");
        else
            $display("tb_gradient_aggregation_slots NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
